// File: sv/cim_pkg.sv
// cim_pkg: shared types, register indexes and widths for the cusum interlock monitor
// used by cim_regs, cim_score and cusum_interlock_monitor_core; depends on nothing
`default_nettype none

package cim_pkg;

  localparam int SCORE_WIDTH = 24;
  localparam int RESID_W     = 17;
  localparam int SUM_W       = ((SCORE_WIDTH > RESID_W) ? SCORE_WIDTH : RESID_W) + 1;
  localparam int CMP_W       = (SCORE_WIDTH > 24) ? SCORE_WIDTH : 24;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  typedef logic [SCORE_WIDTH-1:0] score_t;

  typedef enum logic [1:0] {
    CAUSE_NORMAL  = 2'd0,
    CAUSE_TIMEOUT = 2'd1,
    CAUSE_SCORE   = 2'd2,
    CAUSE_IGNORED = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT   = 3'd0,
    REG_IDLE_EXP  = 3'd1,
    REG_CHG_EXP   = 3'd2,
    REG_DEF_EXP   = 3'd3,
    REG_DRIFT     = 3'd4,
    REG_DECAY     = 3'd5,
    REG_THRESHOLD = 3'd6,
    REG_NONE      = 3'd7
  } reg_idx_t;

  localparam logic [7:0] CODE_IDLE     = 8'd0;
  localparam logic [7:0] CODE_CHARGING = 8'd1;

  typedef struct packed {
    logic [15:0]        timeout_ms;
    logic signed [15:0] idle_expected_volts;
    logic signed [15:0] charging_expected_volts;
    logic signed [15:0] default_expected_volts;
    logic [15:0]        drift_allowance;
    logic [7:0]         decay_factor;
    logic [23:0]        trip_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic [7:0]         state_code;
    logic signed [15:0] measured_volts;
  } sample_t;

  typedef struct packed {
    score_t      anomaly_score;
    logic [31:0] previous_time;
    logic        trip_latch;
  } mon_state_t;

  typedef struct packed {
    logic        tripped;
    cause_t      cause;
    logic [23:0] score;
  } result_t;

endpackage

`default_nettype wire

// File: sv/cim_regs.sv
// cim_regs: apb-style configuration register file for the cusum interlock monitor
// depends on cim_pkg for the register indexes and the configuration struct
`default_nettype none

module cim_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cim_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cim_pkg::DATA_W-1:0] pwdata,
  output logic [cim_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output cim_pkg::cfg_t                   cfg
);

  cim_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = cim_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms              <= 16'd25;
      cfg.idle_expected_volts     <= 16'sd2304;
      cfg.charging_expected_volts <= 16'sd1536;
      cfg.default_expected_volts  <= 16'sd3072;
      cfg.drift_allowance         <= 16'd51;
      cfg.decay_factor            <= 8'd243;
      cfg.trip_threshold          <= 24'd2048;
    end else if (wr) begin
      case (idx)
        cim_pkg::REG_TIMEOUT:   cfg.timeout_ms              <= pwdata[15:0];
        cim_pkg::REG_IDLE_EXP:  cfg.idle_expected_volts     <= $signed(pwdata[15:0]);
        cim_pkg::REG_CHG_EXP:   cfg.charging_expected_volts <= $signed(pwdata[15:0]);
        cim_pkg::REG_DEF_EXP:   cfg.default_expected_volts  <= $signed(pwdata[15:0]);
        cim_pkg::REG_DRIFT:     cfg.drift_allowance         <= pwdata[15:0];
        cim_pkg::REG_DECAY:     cfg.decay_factor            <= pwdata[7:0];
        cim_pkg::REG_THRESHOLD: cfg.trip_threshold          <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cim_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.timeout_ms};
      cim_pkg::REG_IDLE_EXP:  prdata = {16'd0, cfg.idle_expected_volts};
      cim_pkg::REG_CHG_EXP:   prdata = {16'd0, cfg.charging_expected_volts};
      cim_pkg::REG_DEF_EXP:   prdata = {16'd0, cfg.default_expected_volts};
      cim_pkg::REG_DRIFT:     prdata = {16'd0, cfg.drift_allowance};
      cim_pkg::REG_DECAY:     prdata = {24'd0, cfg.decay_factor};
      cim_pkg::REG_THRESHOLD: prdata = {8'd0, cfg.trip_threshold};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/cim_score.sv
// cim_score: single-pass watchdog and cusum score update for one transaction
// depends on cim_pkg for the sample, state, result and configuration structs
`default_nettype none

module cim_score (
  input  wire cim_pkg::cfg_t       cfg,
  input  wire cim_pkg::sample_t    smp,
  input  wire cim_pkg::mon_state_t cur,
  output cim_pkg::mon_state_t      nxt,
  output cim_pkg::result_t         res
);

  localparam int SW = cim_pkg::SCORE_WIDTH;

  logic [31:0]                     gap;
  logic                            timed_out;
  logic signed [15:0]              expect_v;
  logic signed [16:0]              diff;
  logic [cim_pkg::RESID_W-1:0]     residual;
  logic [cim_pkg::RESID_W-1:0]     excess;
  logic                            over_drift;
  logic [cim_pkg::SUM_W-1:0]       sum;
  cim_pkg::score_t                 sat_sum;
  logic [SW+7:0]                   prod;
  cim_pkg::score_t                 new_score;
  logic [cim_pkg::CMP_W-1:0]       score_ext;
  logic [cim_pkg::CMP_W-1:0]       held_ext;
  logic                            score_trip;

  assign gap       = smp.sample_time - cur.previous_time;
  assign timed_out = (cur.previous_time != 32'd0) && (gap > {16'd0, cfg.timeout_ms});

  always_comb begin
    case (smp.state_code)
      cim_pkg::CODE_IDLE:     expect_v = cfg.idle_expected_volts;
      cim_pkg::CODE_CHARGING: expect_v = cfg.charging_expected_volts;
      default:                expect_v = cfg.default_expected_volts;
    endcase
  end

  assign diff       = 17'(smp.measured_volts) - 17'(expect_v);
  assign residual   = diff[16] ? cim_pkg::RESID_W'(-diff) : cim_pkg::RESID_W'(diff);
  assign over_drift = residual > {1'b0, cfg.drift_allowance};
  assign excess     = residual - {1'b0, cfg.drift_allowance};

  assign sum     = cim_pkg::SUM_W'(cur.anomaly_score) + cim_pkg::SUM_W'(excess);
  assign sat_sum = (sum[cim_pkg::SUM_W-1:SW] != '0) ? '1 : sum[SW-1:0];
  assign prod    = (SW+8)'(cur.anomaly_score) * (SW+8)'(cfg.decay_factor);

  assign new_score  = over_drift ? sat_sum : prod[SW+7:8];
  assign score_ext  = cim_pkg::CMP_W'(new_score);
  assign held_ext   = cim_pkg::CMP_W'(cur.anomaly_score);
  assign score_trip = score_ext > cim_pkg::CMP_W'(cfg.trip_threshold);

  always_comb begin
    nxt = cur;
    if (cur.trip_latch) begin
      res.tripped = 1'b1;
      res.cause   = cim_pkg::CAUSE_IGNORED;
      res.score   = held_ext[23:0];
    end else if (timed_out) begin
      nxt.trip_latch = 1'b1;
      res.tripped    = 1'b1;
      res.cause      = cim_pkg::CAUSE_TIMEOUT;
      res.score      = held_ext[23:0];
    end else begin
      nxt.previous_time = smp.sample_time;
      nxt.anomaly_score = new_score;
      nxt.trip_latch    = score_trip;
      res.tripped       = score_trip;
      res.cause         = score_trip ? cim_pkg::CAUSE_SCORE : cim_pkg::CAUSE_NORMAL;
      res.score         = score_ext[23:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/cusum_interlock_monitor_core.sv
// cusum_interlock_monitor_core: top level of the cusum interlock monitor
// depends on cim_pkg, cim_regs and cim_score
//
// samples enter on the sample channel (sample_valid / sample_stall) with a
// timestamp in ms, a state code and a signed q8.8 voltage; one result per
// sample leaves on the result channel (result_valid / result_stall) carrying
// the trip flag, the cause and the low 24 bits of the anomaly score.
// a sample is registered at acceptance; the watchdog check and score update
// then run combinationally from that register into the result register and
// the monitor state, which load together as result_valid is raised.
// throughput is one sample per cycle unless result_stall holds a result.
// while result_stall is high the result holds, and one more sample may wait
// in the input register before sample_stall is raised.
// once tripped, results report cause 3 with the held score until reset.
// reset clears the score, stored timestamp and trip latch, empties both
// registers and loads the configuration defaults; the user must write to
// the apb port only with no transaction in flight, unchecked by the block.
`default_nettype none

module cusum_interlock_monitor_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire logic [31:0]                sample_time,
  input  wire logic [7:0]                 state_code,
  input  wire logic signed [15:0]         measured_volts,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic                            tripped,
  output logic [1:0]                      cause,
  output logic [23:0]                     score,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cim_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cim_pkg::DATA_W-1:0] pwdata,
  output logic [cim_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  cim_pkg::cfg_t       cfg;
  cim_pkg::sample_t    smp;
  logic                smp_valid;
  cim_pkg::mon_state_t mon;
  cim_pkg::mon_state_t mon_next;
  cim_pkg::result_t    res_next;
  cim_pkg::result_t    res;
  logic                advance;
  logic                take;

  cim_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cim_score u_score (
    .cfg (cfg),
    .smp (smp),
    .cur (mon),
    .nxt (mon_next),
    .res (res_next)
  );

  assign advance      = smp_valid && (!result_valid || !result_stall);
  assign sample_stall = smp_valid && !advance;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (take) begin
      smp_valid <= 1'b1;
    end else if (advance) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      smp.sample_time    <= sample_time;
      smp.state_code     <= state_code;
      smp.measured_volts <= measured_volts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mon          <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      mon          <= mon_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign tripped = res.tripped;
  assign cause   = res.cause;
  assign score   = res.score;

endmodule

`default_nettype wire
